// ===== rtl/atce_pkg.sv =====
// ----------------------------------------------------------------------------
// Instruction cycle estimator package
// Decode masks, condition codes, the decode record passed between pipeline
// stages, and the small helper functions used by the input capture and decode stages.
// ----------------------------------------------------------------------------
package atce_pkg;

   // Field widths.
   localparam int unsigned InstrWidth = 32;
   localparam int unsigned RsWidth    = 32;
   localparam int unsigned FlagsWidth = 4;
   localparam int unsigned CountWidth = 5;
   localparam int unsigned PopWidth   = 4;

   // 32-bit instruction decode masks and match patterns.
   localparam logic [31:0] BxMask      = 32'h0FFF_FFF0;
   localparam logic [31:0] BxMatch     = 32'h012F_FF10;
   localparam logic [31:0] MrsMask     = 32'h0FBF_0FFF;
   localparam logic [31:0] MrsMatch    = 32'h010F_0000;
   localparam logic [31:0] MsrRegMask  = 32'h0FB0_FFF0;
   localparam logic [31:0] MsrRegMatch = 32'h0120_F000;
   localparam logic [31:0] MsrImmMask  = 32'h0FB0_F000;
   localparam logic [31:0] MsrImmMatch = 32'h0320_F000;
   localparam logic [31:0] MulMask     = 32'h0FC0_00F0;
   localparam logic [31:0] MulMatch    = 32'h0000_0090;
   localparam logic [31:0] MullMask    = 32'h0F80_00F0;
   localparam logic [31:0] MullMatch   = 32'h0080_0090;
   localparam logic [31:0] SwpMask     = 32'h0FB0_0FF0;
   localparam logic [31:0] SwpMatch    = 32'h0100_0090;
   localparam logic [31:0] HalfMask    = 32'h0E00_0090;
   localparam logic [31:0] HalfMatch   = 32'h0000_0090;

   // Instruction classes selected by bits 27:26 of a 32-bit word.
   localparam logic [1:0] ClassDataProc = 2'b00;
   localparam logic [1:0] ClassSingleXf = 2'b01;
   localparam logic [1:0] ClassBlockXf  = 2'b10;

   // Register number of the program counter.
   localparam logic [3:0] RegPc = 4'hF;

   // Compressed-format prefixes.
   localparam logic [7:0] ThumbAddSp = 8'hB0;
   localparam logic [7:0] ThumbSwi   = 8'hDF;
   localparam logic [3:0] ThumbAluMul = 4'd13;

   // Condition codes.
   typedef enum logic [3:0] {
      COND_EQ = 4'd0,
      COND_NE = 4'd1,
      COND_CS = 4'd2,
      COND_CC = 4'd3,
      COND_MI = 4'd4,
      COND_PL = 4'd5,
      COND_VS = 4'd6,
      COND_VC = 4'd7,
      COND_HI = 4'd8,
      COND_LS = 4'd9,
      COND_GE = 4'd10,
      COND_LT = 4'd11,
      COND_GT = 4'd12,
      COND_LE = 4'd13,
      COND_AL = 4'd14,
      COND_NV = 4'd15
   } cond_type;

   // Decode record carried from the decode stage to the summing stage.
   typedef struct packed {
      logic [CountWidth-1:0] base;
      logic                  pop_lo_en;
      logic                  pop_hi_en;
      logic [PopWidth-1:0]   pop_lo;
      logic [PopWidth-1:0]   pop_hi;
   } dec_type;

   function automatic logic [2:0] mul_signed(input logic [RsWidth-1:0] r);
      logic [2:0] m;
      if (&r[31:8] || ~|r[31:8]) begin
         m = 3'd1;
      end else if (&r[31:16] || ~|r[31:16]) begin
         m = 3'd2;
      end else if (&r[31:24] || ~|r[31:24]) begin
         m = 3'd3;
      end else begin
         m = 3'd4;
      end
      return m;
   endfunction

   function automatic logic [2:0] mul_unsigned(input logic [RsWidth-1:0] r);
      logic [2:0] m;
      if (~|r[31:8]) begin
         m = 3'd1;
      end else if (~|r[31:16]) begin
         m = 3'd2;
      end else if (~|r[31:24]) begin
         m = 3'd3;
      end else begin
         m = 3'd4;
      end
      return m;
   endfunction

   function automatic logic [PopWidth-1:0] pop8(input logic [7:0] v);
      logic [PopWidth-1:0] n;
      n = '0;
      for (int i = 0; i < 8; i++) begin
         n = n + PopWidth'(v[i]);
      end
      return n;
   endfunction

   // Flags are N, Z, C, V in bits 3..0.
   function automatic logic cond_holds(input cond_type c, input logic [FlagsWidth-1:0] f);
      logic n, z, cy, v, ok;
      n  = f[3];
      z  = f[2];
      cy = f[1];
      v  = f[0];
      unique case (c)
         COND_EQ: ok = z;
         COND_NE: ok = !z;
         COND_CS: ok = cy;
         COND_CC: ok = !cy;
         COND_MI: ok = n;
         COND_PL: ok = !n;
         COND_VS: ok = v;
         COND_VC: ok = !v;
         COND_HI: ok = cy && !z;
         COND_LS: ok = !cy || z;
         COND_GE: ok = (n == v);
         COND_LT: ok = (n != v);
         COND_GT: ok = !z && (n == v);
         COND_LE: ok = z || (n != v);
         COND_AL: ok = 1'b1;
         COND_NV: ok = 1'b0;
         default: ok = 1'b0;
      endcase
      return ok;
   endfunction

endpackage

// ===== rtl/arm_thumb_cycle_estimator_top.sv =====
// ----------------------------------------------------------------------------
// Instruction cycle estimator
// Classifies one 32-bit or 16-bit compressed instruction per beat and returns
// the number of cycles it takes, sequential, non-sequential and internal
// cycles added together, with multiply early termination and branch
// conditions taken into account.
//
//   Channel   Ports                                   Handshake
//   request   req_mode, req_instr_word, req_rs_value, start high, busy low
//             req_flags_nzcv
//   response  rsp_cycle_count                         rsp_strobe, one cycle
//
// Three register stages: input capture with the early-termination and
// register-list counts, decode, count summation. A request accepted by the
// capture stage passes through the decode and summation registers, and
// rsp_strobe rises with its count once it reaches the summation register.
// One request is taken every cycle; busy is always low, as nothing downstream
// can hold a response off.
// Reset clears the stage valid bits, so no response follows a request that
// was in flight when reset was applied.
// ----------------------------------------------------------------------------
module arm_thumb_cycle_estimator_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_mode,
   input  logic [atce_pkg::InstrWidth-1:0]     req_instr_word,
   input  logic [atce_pkg::RsWidth-1:0]        req_rs_value,
   input  logic [atce_pkg::FlagsWidth-1:0]     req_flags_nzcv,
   output logic                                rsp_strobe,
   output logic [atce_pkg::CountWidth-1:0]     rsp_cycle_count
);

   // Stage 1: captured request with its precomputed counts.
   logic                             s1_valid_ff, s1_valid_in;
   logic                             s1_mode_ff;
   logic [atce_pkg::InstrWidth-1:0]  s1_instr_ff;
   logic [atce_pkg::FlagsWidth-1:0]  s1_flags_ff;
   logic [2:0]                       s1_ms_ff;
   logic [2:0]                       s1_mu_ff;
   logic [atce_pkg::PopWidth-1:0]    s1_pop_lo_ff;
   logic [atce_pkg::PopWidth-1:0]    s1_pop_hi_ff;

   // Stage 2: decode record.
   logic                             s2_valid_ff;
   atce_pkg::dec_type                s2_dec_ff, s2_dec_in;

   // Stage 3: final count.
   logic                             s3_valid_ff;
   logic [atce_pkg::CountWidth-1:0]  s3_count_ff, s3_count_in;

   assign busy        = 1'b0;
   assign s1_valid_in = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_in) begin
         s1_mode_ff   <= req_mode;
         s1_instr_ff  <= req_instr_word;
         s1_flags_ff  <= req_flags_nzcv;
         s1_ms_ff     <= atce_pkg::mul_signed(req_rs_value);
         s1_mu_ff     <= atce_pkg::mul_unsigned(req_rs_value);
         s1_pop_lo_ff <= atce_pkg::pop8(req_instr_word[7:0]);
         s1_pop_hi_ff <= atce_pkg::pop8(req_instr_word[15:8]);
      end
      s2_dec_ff   <= s2_dec_in;
      s3_count_ff <= s3_count_in;
   end

   // Decode stage: class, fixed part of the count, register-list counts.
   always_comb begin
      logic [31:0] w;
      logic [15:0] h;
      logic [2:0]  ms;
      logic [2:0]  mu;
      logic        wload;
      logic        hload;
      logic        regsh;
      logic        test_op;
      logic        pc_dst;
      logic        extra;

      w       = s1_instr_ff;
      h       = s1_instr_ff[15:0];
      ms      = s1_ms_ff;
      mu      = s1_mu_ff;
      wload   = w[20];
      hload   = h[11];
      regsh   = !w[25] && w[4];
      // TST, TEQ, CMP and CMN never write a destination register.
      test_op = (w[24:23] == 2'b10);
      pc_dst  = !test_op && (w[15:12] == atce_pkg::RegPc);
      extra   = h[8];

      s2_dec_in.base      = 5'd1;
      s2_dec_in.pop_lo_en = 1'b0;
      s2_dec_in.pop_hi_en = 1'b0;
      s2_dec_in.pop_lo    = s1_pop_lo_ff;
      s2_dec_in.pop_hi    = s1_pop_hi_ff;

      if (!s1_mode_ff) begin
         priority if ((w & atce_pkg::BxMask) == atce_pkg::BxMatch) begin
            s2_dec_in.base = 5'd3;
         end else if ((w & atce_pkg::MrsMask) == atce_pkg::MrsMatch ||
                      (w & atce_pkg::MsrRegMask) == atce_pkg::MsrRegMatch ||
                      (w & atce_pkg::MsrImmMask) == atce_pkg::MsrImmMatch) begin
            s2_dec_in.base = 5'd1;
         end else if ((w & atce_pkg::MulMask) == atce_pkg::MulMatch) begin
            s2_dec_in.base = 5'd1 + 5'(ms) + 5'(w[21]);
         end else if ((w & atce_pkg::MullMask) == atce_pkg::MullMatch) begin
            s2_dec_in.base = 5'd2 + 5'(w[22] ? ms : mu) + 5'(w[21]);
         end else if ((w & atce_pkg::SwpMask) == atce_pkg::SwpMatch) begin
            s2_dec_in.base = 5'd4;
         end else if ((w & atce_pkg::HalfMask) == atce_pkg::HalfMatch) begin
            s2_dec_in.base = wload ? 5'd3 : 5'd2;
         end else if (w[27:26] == atce_pkg::ClassDataProc) begin
            s2_dec_in.base = 5'd1 + 5'(regsh) + (pc_dst ? 5'd2 : 5'd0);
         end else if (w[27:26] == atce_pkg::ClassSingleXf) begin
            if (w[25] && w[4]) begin
               s2_dec_in.base = 5'd3;
            end else if (!wload) begin
               s2_dec_in.base = 5'd2;
            end else begin
               s2_dec_in.base = (w[15:12] == atce_pkg::RegPc) ? 5'd5 : 5'd3;
            end
         end else if (w[27:26] == atce_pkg::ClassBlockXf) begin
            if (w[25]) begin
               s2_dec_in.base = 5'd3;
            end else begin
               // An empty store list costs one cycle, the same as n + 1.
               s2_dec_in.pop_lo_en = 1'b1;
               s2_dec_in.pop_hi_en = 1'b1;
               s2_dec_in.base      = wload ? (w[15] ? 5'd4 : 5'd2) : 5'd1;
            end
         end else begin
            s2_dec_in.base = 5'd3;
         end
      end else begin
         priority if (h[15:11] == 5'd3 || h[15:13] == 3'd0 || h[15:13] == 3'd1) begin
            s2_dec_in.base = 5'd1;
         end else if (h[15:10] == 6'h10) begin
            s2_dec_in.base = (h[9:6] == atce_pkg::ThumbAluMul) ? 5'd1 + 5'(ms) : 5'd1;
         end else if (h[15:10] == 6'h11) begin
            if (h[9:8] == 2'd3) begin
               s2_dec_in.base = 5'd3;
            end else if (h[9:8] == 2'd1) begin
               s2_dec_in.base = 5'd1;
            end else begin
               // High-register ADD or MOV into the program counter.
               s2_dec_in.base = (h[7] && h[2:0] == 3'd7) ? 5'd3 : 5'd1;
            end
         end else if (h[15:11] == 5'd9) begin
            s2_dec_in.base = 5'd3;
         end else if (h[15:12] == 4'd5 || h[15:13] == 3'd3 ||
                      h[15:12] == 4'd8 || h[15:12] == 4'd9) begin
            s2_dec_in.base = hload ? 5'd3 : 5'd2;
         end else if (h[15:12] == 4'd10 || h[15:8] == atce_pkg::ThumbAddSp) begin
            s2_dec_in.base = 5'd1;
         end else if (h[15:12] == 4'd11 && h[10:9] == 2'd2) begin
            // The extra register counts in the list; a POP of it costs two more.
            s2_dec_in.pop_lo_en = 1'b1;
            s2_dec_in.base      = hload ? (extra ? 5'd5 : 5'd2) : (extra ? 5'd2 : 5'd1);
         end else if (h[15:12] == 4'd12) begin
            s2_dec_in.pop_lo_en = 1'b1;
            s2_dec_in.base      = hload ? 5'd2 : 5'd1;
         end else if (h[15:8] == atce_pkg::ThumbSwi) begin
            s2_dec_in.base = 5'd3;
         end else if (h[15:12] == 4'd13) begin
            s2_dec_in.base = atce_pkg::cond_holds(atce_pkg::cond_type'(h[11:8]),
                                                  s1_flags_ff) ? 5'd3 : 5'd1;
         end else if (h[15:11] == 5'h1C) begin
            s2_dec_in.base = 5'd3;
         end else if (h[15:12] == 4'd15) begin
            s2_dec_in.base = hload ? 5'd3 : 5'd1;
         end else begin
            s2_dec_in.base = 5'd1;
         end
      end
   end

   // Summing stage.
   always_comb begin
      s3_count_in = s2_dec_ff.base
                  + (s2_dec_ff.pop_lo_en ? 5'(s2_dec_ff.pop_lo) : 5'd0)
                  + (s2_dec_ff.pop_hi_en ? 5'(s2_dec_ff.pop_hi) : 5'd0);
   end

   assign rsp_strobe      = s3_valid_ff;
   assign rsp_cycle_count = s3_count_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_strobe)
      else $error("accepted request produced no response after three cycles");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, 3))
      else $error("response without a matching request");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_cycle_count >= 5'd1 && rsp_cycle_count <= 5'd20))
      else $error("cycle count out of range");

   a_base_nonzero: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (s2_dec_ff.base != 5'd0))
      else $error("decode produced a zero base count");

endmodule
